/* design/wls_pkg.sv */
`default_nettype none

package wls_pkg;

    // Stream framing
    localparam int HEADER_BYTES    = 60;
    localparam int LEN_FIELD_BYTES = 32;
    localparam int POS_W           = 21;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Password
    localparam int KEY_BYTES = 10;
    localparam int KEY_IDX_W = 4;
    localparam int KEY_SLOTS = 2 ** KEY_IDX_W;

    // Length field split: value / 255 by reciprocal multiply
    localparam logic [15:0] DIV255_RECIP = 16'h8081;
    localparam int          DIV255_SHIFT = 23;

    // Configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REG_MSG_LEN  = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_KEY_HIGH = 2'd2,
        REG_KEY_LEN  = 2'd3
    } t_reg_idx;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_COVER = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TAIL    = 2'd3
    } t_phase;

    typedef logic [KEY_SLOTS-1:0][7:0] t_key;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [15:0]          len_field;
        logic [POS_W-1:0]     pay_end;
        t_key                 key;
        logic [KEY_IDX_W-1:0] key_len;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        logic   underrun;
        logic   bit_embedded;
    } t_result_user;

endpackage

`default_nettype wire

/* design/wls_cfg.sv */
`default_nettype none

module wls_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wls_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [wls_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [wls_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output wls_pkg::t_cfg                       o_cfg
);
    import wls_pkg::*;

    logic [15:0]          r_msg_len;
    logic [63:0]          r_key_low;
    logic [15:0]          r_key_high;
    logic [KEY_IDX_W-1:0] r_key_len_raw;
    logic [KEY_IDX_W-1:0] r_key_len_eff;
    logic [15:0]          r_len_field;
    logic [POS_W-1:0]     r_pay_end;

    t_reg_idx             w_idx;
    logic                 w_wr;
    logic [15:0]          w_len;
    logic [31:0]          w_prod;
    logic [8:0]           w_quot;
    logic [16:0]          w_rem;
    logic [KEY_IDX_W-1:0] w_klen;

    assign w_idx = t_reg_idx'(paddr[APB_ADDR_W-1:APB_ADDR_W-2]);
    assign w_wr  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Split the new length into quotient and remainder by 255
    assign w_len  = pwdata[15:0];
    assign w_prod = w_len * DIV255_RECIP;
    assign w_quot = w_prod[31:DIV255_SHIFT];
    assign w_rem  = 17'(w_len) + 17'(w_quot) - {w_quot, 8'h00};

    // Clamp the password length to 1..KEY_BYTES
    always_comb begin
        w_klen = pwdata[KEY_IDX_W-1:0];
        if (w_klen == '0) begin
            w_klen = KEY_IDX_W'(1);
        end else if (w_klen > KEY_IDX_W'(KEY_BYTES)) begin
            w_klen = KEY_IDX_W'(KEY_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len     <= '0;
            r_key_low     <= '0;
            r_key_high    <= '0;
            r_key_len_raw <= KEY_IDX_W'(1);
            r_key_len_eff <= KEY_IDX_W'(1);
            r_len_field   <= '0;
            r_pay_end     <= POS_W'(LEN_FIELD_BYTES);
        end else if (w_wr) begin
            case (w_idx)
                REG_MSG_LEN: begin
                    r_msg_len   <= w_len;
                    r_len_field <= {w_quot[7:0], w_rem[7:0]};
                    r_pay_end   <= POS_W'(LEN_FIELD_BYTES) + POS_W'({w_len, 4'h0});
                end
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_KEY_HIGH: r_key_high <= pwdata[15:0];
                REG_KEY_LEN: begin
                    r_key_len_raw <= pwdata[KEY_IDX_W-1:0];
                    r_key_len_eff <= w_klen;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MSG_LEN:  prdata = APB_DATA_W'(r_msg_len);
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_HIGH: prdata = APB_DATA_W'(r_key_high);
            REG_KEY_LEN:  prdata = APB_DATA_W'(r_key_len_raw);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.len_field = r_len_field;
        o_cfg.pay_end   = r_pay_end;
        o_cfg.key_len   = r_key_len_eff;
        o_cfg.key       = '0;
        for (int b = 0; b < 8; b++) begin
            o_cfg.key[b] = r_key_low[8*b +: 8];
        end
        o_cfg.key[8] = r_key_high[7:0];
        o_cfg.key[9] = r_key_high[15:8];
    end

endmodule

`default_nettype wire

/* design/wls_front.sv */
`default_nettype none

module wls_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output wls_pkg::t_item  o_item
);
    import wls_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Hold one item; take the next when the queue drains this one
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.kind <= i_opcode ? KIND_COVER : KIND_LOAD;
            r_item.data <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/wls_queue.sv */
`default_nettype none

module wls_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_valid,
    output logic                o_wr_ready,
    input  wire wls_pkg::t_item i_wr_item,
    output logic                o_rd_valid,
    input  wire logic           i_rd_pop,
    output wls_pkg::t_item      o_rd_item
);
    import wls_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_wr_ready = r_count != (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_rd_valid = r_count != '0;
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = i_rd_pop && o_rd_valid;
    assign o_rd_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/wls_back.sv */
`default_nettype none

module wls_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wls_pkg::t_cfg     i_cfg,
    input  wire logic              i_head_valid,
    input  wire wls_pkg::t_item    i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_stego,
    output wls_pkg::t_result_user  o_user
);
    import wls_pkg::*;

    logic [POS_W-1:0]     r_pos, n_pos;
    logic [7:0]           r_shift, n_shift;
    logic [7:0]           r_held, n_held;
    logic                 r_held_valid, n_held_valid;
    logic [KEY_IDX_W-1:0] r_key_idx, n_key_idx;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_stego, n_out_stego;
    t_result_user         r_out_user, n_out_user;

    logic                 w_is_cover;
    logic                 w_out_free;
    logic [POS_W-1:0]     w_off;
    logic [KEY_IDX_W-1:0] w_idx;
    logic [7:0]           w_sh;

    assign w_is_cover = i_head.kind == KIND_COVER;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = i_head_valid && (!w_is_cover || w_out_free);
    assign w_off      = r_pos - POS_W'(HEADER_BYTES);

    assign o_valid = r_out_valid;
    assign o_stego = r_out_stego;
    assign o_user  = r_out_user;

    always_comb begin
        n_pos        = r_pos;
        n_shift      = r_shift;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_key_idx    = r_key_idx;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_stego  = r_out_stego;
        n_out_user   = r_out_user;
        w_idx        = (r_key_idx < i_cfg.key_len) ? r_key_idx : '0;
        w_sh         = r_shift;

        if (o_pop && !w_is_cover) begin
            // Message load: overwrite whatever is held
            n_held       = i_head.data;
            n_held_valid = 1'b1;
        end else if (o_pop) begin
            n_out_valid             = 1'b1;
            n_out_stego             = i_head.data;
            n_out_user.bit_embedded = 1'b0;
            n_out_user.underrun     = 1'b0;
            if (r_pos < POS_W'(HEADER_BYTES)) begin
                n_out_user.phase = PH_HEADER;
            end else if (w_off < POS_W'(LEN_FIELD_BYTES)) begin
                n_out_user.phase = PH_LENGTH;
                if (!w_off[0]) begin
                    n_out_stego[0]          = i_cfg.len_field[~w_off[4:1]];
                    n_out_user.bit_embedded = 1'b1;
                end
            end else if (w_off < i_cfg.pay_end) begin
                n_out_user.phase = PH_PAYLOAD;
                if (w_off[3:0] == 4'h0) begin
                    // Start of a payload byte: load the shifter, advance the key
                    if (r_held_valid) begin
                        w_sh         = r_held + i_cfg.key[w_idx];
                        n_held_valid = 1'b0;
                    end else begin
                        w_sh                = '0;
                        n_out_user.underrun = 1'b1;
                    end
                    n_key_idx = (w_idx + 1'b1 >= i_cfg.key_len) ? '0 : w_idx + 1'b1;
                end
                if (!w_off[0]) begin
                    n_out_stego[0]          = w_sh[7];
                    n_out_user.bit_embedded = 1'b1;
                    w_sh                    = {w_sh[6:0], 1'b0};
                end
                n_shift = w_sh;
            end else begin
                n_out_user.phase = PH_TAIL;
            end
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_shift      <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_key_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_shift      <= n_shift;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_key_idx    <= n_key_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_stego <= n_out_stego;
        r_out_user  <= n_out_user;
    end

`ifndef NO_ASSERTIONS
    a_underrun_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user.underrun |->
            r_out_user.bit_embedded && r_out_user.phase == PH_PAYLOAD)
        else $error("underrun flagged outside an embedded payload bit");

    a_embed_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user.bit_embedded |->
            r_out_user.phase == PH_LENGTH || r_out_user.phase == PH_PAYLOAD)
        else $error("bit embedded in header or tail");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && w_is_cover |=>
            r_pos == $past(r_pos) + 1'b1 || $past(r_pos) == POS_MAX)
        else $error("cover position did not advance");

    a_key_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && w_is_cover |=> r_key_idx < KEY_IDX_W'(KEY_BYTES))
        else $error("password index out of range");
`endif

endmodule

`default_nettype wire

/* design/wav_lsb_stego_embedder.sv */
`default_nettype none

// Channel      Dir   Handshake                tdata / tuser
// s_axis       in    tvalid/tready            tdata: data_byte; tuser: opcode
// m_axis       out   tvalid/tready            tdata: stego_byte; tuser: embedded,
//                                             underrun, phase
// apb          in    psel/penable/pwrite      4 regs at 8*i, 64-bit data
//
// One item per cycle in steady state while the output is not stalled, loads
// and cover bytes alike; a cover byte's result passes the input register,
// the two-entry queue and the output register before it can transfer.
// Reset is synchronous and active low; it clears all control state and sets
// the configuration registers to their defaults.
// Input and output stall independently: the queue absorbs output stalls
// until it fills, then tready on the input side drops.

module wav_lsb_stego_embedder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic                           i_s_axis_tuser,  // [0] opcode
    // output stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [7:0]                          o_m_axis_tdata,  // [7:0] stego_byte
    output logic [3:0]                          o_m_axis_tuser,  // [0] bit_embedded,
                                                                 // [1] underrun,
                                                                 // [3:2] phase
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wls_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [wls_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [wls_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import wls_pkg::*;

    t_cfg         w_cfg;
    logic         w_front_valid;
    logic         w_queue_ready;
    t_item        w_front_item;
    logic         w_head_valid;
    t_item        w_head;
    logic         w_pop;
    t_result_user w_user;

    // Register file; length split and payload end are precomputed on write
    wls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Front: take each transfer and tag it as a message load or a cover byte
    wls_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_opcode (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .o_valid  (w_front_valid),
        .i_ready  (w_queue_ready),
        .o_item   (w_front_item)
    );

    // Keep loads and cover bytes in order between front and back
    wls_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_queue_ready),
        .i_wr_item  (w_front_item),
        .o_rd_valid (w_head_valid),
        .i_rd_pop   (w_pop),
        .o_rd_item  (w_head)
    );

    // Back: track position, hold the message byte, embed bits, drive results
    wls_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_stego      (o_m_axis_tdata),
        .o_user       (w_user)
    );

    assign o_m_axis_tuser = w_user;

endmodule

`default_nettype wire
